// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros shared by the rtl modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, masked while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/gmr_pkg.sv =====
// ----------------------------------------------------------------------------
// gmr_pkg
// shared constants, types and helpers of the genotype missing-rate filter
// ----------------------------------------------------------------------------
package gmr_pkg;

  localparam int MAX_GENOTYPES = 32768;
  localparam int CNT_W         = 17;
  localparam int FIELD_MAX     = 131071;
  localparam int CAP_INT       = (2 * MAX_GENOTYPES > FIELD_MAX) ? FIELD_MAX
                                                                 : 2 * MAX_GENOTYPES;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

  localparam int THR_W  = 17;
  localparam int FRAC_W = 16;
  localparam int INC_W  = 3;

  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_REF = 8'h30;
  localparam logic [7:0] CHAR_ALT = 8'h31;

  localparam logic [1:0] CLS_REF  = 2'd0;
  localparam logic [1:0] CLS_ALT  = 2'd1;
  localparam logic [1:0] CLS_MISS = 2'd2;

  localparam logic [1:0] POS_0 = 2'd0;
  localparam logic [1:0] POS_1 = 2'd1;
  localparam logic [1:0] POS_2 = 2'd2;
  localparam logic [1:0] POS_3 = 2'd3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1 << FRAC_W);

  typedef struct packed {
    logic [CNT_W-1:0] ref_cnt;
    logic [CNT_W-1:0] obs_cnt;
    logic [CNT_W-1:0] slot_cnt;
  } line_totals_t;

  function automatic logic [1:0] allele_class(input logic [7:0] ch);
    logic [1:0] cls;
    if (ch == CHAR_REF) begin
      cls = CLS_REF;
    end else if (ch == CHAR_ALT) begin
      cls = CLS_ALT;
    end else begin
      cls = CLS_MISS;
    end
    return cls;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [INC_W-1:0] a);
    logic [CNT_W:0] s;
    s = {1'b0, v} + {{(CNT_W + 1 - INC_W){1'b0}}, a};
    return (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[CNT_W-1:0];
  endfunction

  // slots added when a field closes at the given position
  function automatic logic [INC_W-1:0] close_slots(input logic [1:0] pos);
    logic [INC_W-1:0] n;
    case (pos)
      POS_0, POS_1: n = INC_W'(2);
      POS_2:        n = INC_W'(1);
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/genotype_missing_rate_filter.sv =====
// ----------------------------------------------------------------------------
// genotype_missing_rate_filter
// counts alleles of the genotype columns of a text line, byte by byte, and
// reports minor, observed and total allele counts with a missing-rate verdict
// ----------------------------------------------------------------------------
// a line's result goes from its last beat via the input, totals and output registers
// throughput: one byte per cycle while in_tready is high; single counter update stage
// output register and totals register let input flow while a result waits
// reset clears counters and field state, threshold returns to 65536
module genotype_missing_rate_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,    // missing_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // text_byte
  input  logic        in_tlast,     // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // minor_count, observed_count, total_count, zero pad
  output logic        out_tuser     // keep
);

  logic [gmr_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic                      tot_valid, tot_ready;
  gmr_pkg::line_totals_t     tot;
  logic [gmr_pkg::CNT_W-1:0] minor_count, observed_count, total_count;
  logic                      keep;

  assign thr_nxt = cfg_we ? cfg_wdata : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gmr_pkg::THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  gmr_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .tot_valid (tot_valid),
    .tot_ready (tot_ready),
    .tot       (tot)
  );

  gmr_judge u_judge (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (thr_r),
    .tot_valid      (tot_valid),
    .tot_ready      (tot_ready),
    .tot            (tot),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .minor_count    (minor_count),
    .observed_count (observed_count),
    .total_count    (total_count),
    .keep           (keep)
  );

  assign out_tdata = {5'b0, total_count, observed_count, minor_count};
  assign out_tuser = keep;

endmodule

// ===== rtl/core/gmr_counter.sv =====
// ----------------------------------------------------------------------------
// gmr_counter
// input register, per-byte field parser and allele counters; line totals out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmr_counter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  tot_valid,
  input  logic                  tot_ready,
  output gmr_pkg::line_totals_t tot
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic [7:0]                 s1_byte_r;
  logic                       s1_last_r;
  logic                       s1_take;

  logic [1:0]                 pos_r, pos_nxt;
  logic [1:0]                 fcls_r, fcls_nxt;
  logic [gmr_pkg::CNT_W-1:0]  ref_r, ref_nxt;
  logic [gmr_pkg::CNT_W-1:0]  obs_r, obs_nxt;
  logic [gmr_pkg::CNT_W-1:0]  slot_r, slot_nxt;

  logic                       tot_valid_r, tot_valid_nxt;
  gmr_pkg::line_totals_t      tot_r;

  logic [1:0]                 pos_a, fcls_a, cnt_cls;
  logic                       cnt_en;
  logic [gmr_pkg::INC_W-1:0]  slot_inc, ref_inc, obs_inc;
  logic [gmr_pkg::CNT_W-1:0]  ref_sum, obs_sum, slot_sum;

  assign s1_take  = s1_valid_r && (!s1_last_r || !tot_valid_r || tot_ready);
  assign in_ready = !s1_valid_r || s1_take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // field parse for the registered byte
  always_comb begin
    pos_a    = pos_r;
    fcls_a   = fcls_r;
    cnt_en   = 1'b0;
    cnt_cls  = gmr_pkg::CLS_MISS;
    slot_inc = '0;
    if (s1_byte_r == gmr_pkg::CHAR_TAB) begin
      slot_inc = gmr_pkg::close_slots(pos_r);
      pos_a    = gmr_pkg::POS_0;
      fcls_a   = gmr_pkg::CLS_MISS;
    end else begin
      case (pos_r)
        gmr_pkg::POS_0: begin
          fcls_a = gmr_pkg::allele_class(s1_byte_r);
          pos_a  = gmr_pkg::POS_1;
        end
        gmr_pkg::POS_1: begin
          cnt_en  = 1'b1;
          cnt_cls = fcls_r;
          pos_a   = gmr_pkg::POS_2;
        end
        gmr_pkg::POS_2: begin
          cnt_en  = 1'b1;
          cnt_cls = gmr_pkg::allele_class(s1_byte_r);
          pos_a   = gmr_pkg::POS_3;
        end
        default: begin
          pos_a = pos_r;
        end
      endcase
    end
    if (cnt_en) begin
      slot_inc = slot_inc + gmr_pkg::INC_W'(1);
    end
    if (s1_last_r) begin
      slot_inc = slot_inc + gmr_pkg::close_slots(pos_a);
    end
    ref_inc = (cnt_en && cnt_cls == gmr_pkg::CLS_REF) ? gmr_pkg::INC_W'(1) : '0;
    obs_inc = (cnt_en && (cnt_cls == gmr_pkg::CLS_REF || cnt_cls == gmr_pkg::CLS_ALT))
              ? gmr_pkg::INC_W'(1) : '0;
  end

  assign ref_sum  = gmr_pkg::sat_add(ref_r, ref_inc);
  assign obs_sum  = gmr_pkg::sat_add(obs_r, obs_inc);
  assign slot_sum = gmr_pkg::sat_add(slot_r, slot_inc);

  always_comb begin
    pos_nxt  = pos_r;
    fcls_nxt = fcls_r;
    ref_nxt  = ref_r;
    obs_nxt  = obs_r;
    slot_nxt = slot_r;
    if (s1_take) begin
      if (s1_last_r) begin
        pos_nxt  = gmr_pkg::POS_0;
        fcls_nxt = gmr_pkg::CLS_MISS;
        ref_nxt  = '0;
        obs_nxt  = '0;
        slot_nxt = '0;
      end else begin
        pos_nxt  = pos_a;
        fcls_nxt = fcls_a;
        ref_nxt  = ref_sum;
        obs_nxt  = obs_sum;
        slot_nxt = slot_sum;
      end
    end
  end

  always_comb begin
    tot_valid_nxt = tot_valid_r && !tot_ready;
    if (s1_take && s1_last_r) begin
      tot_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= gmr_pkg::POS_0;
      fcls_r      <= gmr_pkg::CLS_MISS;
      ref_r       <= '0;
      obs_r       <= '0;
      slot_r      <= '0;
      tot_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      fcls_r      <= fcls_nxt;
      ref_r       <= ref_nxt;
      obs_r       <= obs_nxt;
      slot_r      <= slot_nxt;
      tot_valid_r <= tot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
    if (s1_take && s1_last_r) begin
      tot_r.ref_cnt  <= ref_sum;
      tot_r.obs_cnt  <= obs_sum;
      tot_r.slot_cnt <= slot_sum;
    end
  end

  assign tot_valid = tot_valid_r;
  assign tot       = tot_r;

  `ASSERT_CLK(a_cnt_order, clk, rst_n, (ref_r <= obs_r) && (obs_r <= slot_r),
              "allele counters out of order")
  `ASSERT_CLK(a_cnt_cap, clk, rst_n, slot_r <= gmr_pkg::COUNT_CAP,
              "slot counter above cap")
  `ASSERT_CLK(a_line_clear, clk, rst_n, (s1_take && s1_last_r) |=>
              (slot_r == '0 && pos_r == gmr_pkg::POS_0 && tot_valid_r),
              "line end did not clear counters")

endmodule

// ===== rtl/core/gmr_judge.sv =====
// ----------------------------------------------------------------------------
// gmr_judge
// minor count and missing-fraction compare, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmr_judge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gmr_pkg::THR_W-1:0] threshold,
  input  logic                      tot_valid,
  output logic                      tot_ready,
  input  gmr_pkg::line_totals_t     tot,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gmr_pkg::CNT_W-1:0] minor_count,
  output logic [gmr_pkg::CNT_W-1:0] observed_count,
  output logic [gmr_pkg::CNT_W-1:0] total_count,
  output logic                      keep
);

  localparam int PROD_W = gmr_pkg::THR_W + gmr_pkg::CNT_W;

  logic                      out_valid_r, out_valid_nxt;
  logic [gmr_pkg::CNT_W-1:0] minor_r, obs_r, slot_r;
  logic                      keep_r;
  logic                      load;

  logic [gmr_pkg::CNT_W-1:0] alt_cnt, minor_c, missing;
  logic [PROD_W-1:0]         lhs, rhs;
  logic                      keep_c;

  assign tot_ready = !out_valid_r || out_ready;
  assign load      = tot_valid && tot_ready;

  always_comb begin
    alt_cnt = tot.obs_cnt - tot.ref_cnt;
    minor_c = (tot.ref_cnt < alt_cnt) ? tot.ref_cnt : alt_cnt;
    missing = tot.slot_cnt - tot.obs_cnt;
    lhs     = {{(PROD_W - gmr_pkg::CNT_W - gmr_pkg::FRAC_W){1'b0}}, missing,
               {gmr_pkg::FRAC_W{1'b0}}};
    rhs     = PROD_W'(threshold) * PROD_W'(tot.slot_cnt);
    keep_c  = (tot.slot_cnt == '0) || (lhs <= rhs);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      minor_r <= minor_c;
      obs_r   <= tot.obs_cnt;
      slot_r  <= tot.slot_cnt;
      keep_r  <= keep_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign minor_count    = minor_r;
  assign observed_count = obs_r;
  assign total_count    = slot_r;
  assign keep           = keep_r;

  `ASSERT_CLK(a_minor_half, clk, rst_n, out_valid_r |->
              ({1'b0, minor_r} + {1'b0, minor_r} <= {1'b0, obs_r}),
              "minor count above half of observed")
  `ASSERT_CLK(a_obs_le_total, clk, rst_n, out_valid_r |-> (obs_r <= slot_r),
              "observed count above total")
  `ASSERT_CLK(a_empty_keep, clk, rst_n, (out_valid_r && slot_r == '0) |-> keep_r,
              "empty line not kept")

endmodule
